### sv/bmmd_pkg.sv
package bmmd_pkg;

  // request kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_LOAD  = 2'd2
  } req_type_t;

  // region codes carried on the output tuser
  typedef enum logic [1:0] {
    REGION_RAM  = 2'd0,
    REGION_ROM  = 2'd1,
    REGION_FB   = 2'd2,
    REGION_NONE = 2'd3
  } region_t;

  // block phase: framebuffer clearing pass, then normal operation
  typedef enum logic {
    PH_CLEAR = 1'b0,
    PH_RUN   = 1'b1
  } phase_t;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BYTES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_BASE   = 3'd4;

  // fixed bus and image geometry
  localparam int ADDR_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int ROM_AW     = 18;
  localparam int ROM_SIZE_W = 19;
  localparam int ROM_DEPTH  = 262144;
  localparam logic [ROM_SIZE_W-1:0] ROM_DEPTH_L = 19'd262144;
  localparam logic [ADDR_W-1:0] BANK_PORT = 16'hFF00;
  localparam logic [BYTE_W-1:0] UNMAPPED_BYTE = 8'h00;

  // reset values of the window registers
  localparam logic [ADDR_W-1:0] RAM_START_RST = 16'h0000;
  localparam logic [ADDR_W-1:0] RAM_BYTES_RST = 16'h0000;
  localparam logic [ADDR_W-1:0] ROM_START_RST = 16'hC000;
  localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_RST = 19'd0;
  localparam logic [ADDR_W-1:0] FB_BASE_RST  = 16'h2000;

  // window decode flags for one bus address
  typedef struct packed {
    logic ram_hit;
    logic rom_hit;
    logic fb_hit;
    logic bank_wr;
  } decode_t;

endpackage

### sv/bmmd_decode.sv
module bmmd_decode #(
  parameter int RAM_DEPTH      = 32768,
  parameter int BANK_BYTES     = 16384,
  parameter int BANK_COUNT_MAX = 16,
  parameter int FB_BYTES       = 1024,
  localparam int RAM_AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1,
  localparam int FB_AW  = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1,
  localparam int BS_W   = (BANK_COUNT_MAX > 1) ? $clog2(BANK_COUNT_MAX) : 1
) (
  input  logic [bmmd_pkg::ADDR_W-1:0]     address,
  input  logic [bmmd_pkg::BYTE_W-1:0]     write_data,
  input  logic [bmmd_pkg::ADDR_W-1:0]     ram_start,
  input  logic [bmmd_pkg::ADDR_W-1:0]     ram_bytes,
  input  logic [bmmd_pkg::ADDR_W-1:0]     rom_start,
  input  logic [bmmd_pkg::ROM_SIZE_W-1:0] rom_size,
  input  logic [bmmd_pkg::ADDR_W-1:0]     fb_base,
  input  logic [BS_W-1:0]                 bank_sel,
  output bmmd_pkg::decode_t               dec,
  output logic [RAM_AW-1:0]               ram_idx,
  output logic [bmmd_pkg::ROM_AW-1:0]     rom_idx,
  output logic [FB_AW-1:0]                fb_idx
);
  import bmmd_pkg::*;

  localparam int OFF_RAW = $clog2(BANK_COUNT_MAX * BANK_BYTES);
  localparam int OFF_W   = (OFF_RAW > ROM_SIZE_W) ? OFF_RAW : ROM_SIZE_W;
  localparam int BW_RAW  = BYTE_W + $clog2(BANK_BYTES);
  localparam int BW_W    = (BW_RAW > ROM_SIZE_W) ? BW_RAW : ROM_SIZE_W;
  localparam logic [ADDR_W:0] RAM_DEPTH_L  = (ADDR_W+1)'(RAM_DEPTH);
  localparam logic [ADDR_W:0] BANK_BYTES_L = (ADDR_W+1)'(BANK_BYTES);
  localparam logic [ADDR_W:0] FB_BYTES_L   = (ADDR_W+1)'(FB_BYTES);
  localparam logic [BYTE_W:0] BANK_MAX_L   = (BYTE_W+1)'(BANK_COUNT_MAX);

  logic [ADDR_W:0]     addr_x;
  logic [ADDR_W:0]     ram_lim;
  logic [ADDR_W:0]     ram_end;
  logic [ADDR_W:0]     rom_end;
  logic [ADDR_W:0]     fb_end;
  logic [ADDR_W-1:0]   ram_rel;
  logic [ADDR_W-1:0]   rom_rel;
  logic [ADDR_W-1:0]   fb_rel;
  logic [ROM_SIZE_W-1:0] eff_size;
  logic [OFF_W-1:0]    rom_off;
  logic [BW_W-1:0]     bank_floor;
  logic                rom_win;

  // window ends without wrap
  always_comb begin
    addr_x  = {1'b0, address};
    ram_lim = ({1'b0, ram_bytes} > RAM_DEPTH_L) ? RAM_DEPTH_L : {1'b0, ram_bytes};
    ram_end = {1'b0, ram_start} + ram_lim;
    rom_end = {1'b0, rom_start} + BANK_BYTES_L;
    fb_end  = {1'b0, fb_base} + FB_BYTES_L;
    eff_size = (rom_size > ROM_DEPTH_L) ? ROM_DEPTH_L : rom_size;
  end

  // offsets inside each window
  always_comb begin
    ram_rel = address - ram_start;
    rom_rel = address - rom_start;
    fb_rel  = address - fb_base;
    rom_off = OFF_W'(rom_rel) + OFF_W'(bank_sel) * OFF_W'(BANK_BYTES);
    // the written byte selects a real bank when its first byte lies inside the image
    bank_floor = BW_W'(write_data) * BW_W'(BANK_BYTES);
  end

  // hit flags and store indexes
  always_comb begin
    rom_win     = (rom_size != '0) && (addr_x >= {1'b0, rom_start}) && (addr_x < rom_end);
    dec.ram_hit = (addr_x >= {1'b0, ram_start}) && (addr_x < ram_end);
    dec.rom_hit = rom_win && (rom_off < OFF_W'(eff_size));
    dec.fb_hit  = (addr_x >= {1'b0, fb_base}) && (addr_x < fb_end);
    dec.bank_wr = (address == BANK_PORT) && ({1'b0, write_data} < BANK_MAX_L) &&
                  (bank_floor < BW_W'(eff_size));
    ram_idx = ram_rel[RAM_AW-1:0];
    rom_idx = rom_off[ROM_AW-1:0];
    fb_idx  = fb_rel[FB_AW-1:0];
  end

endmodule

### sv/banked_memory_map_decoder.sv
// Memory map for an 8-bit CPU bus with a RAM window, a bank-switched ROM
// window and a framebuffer window.
// Input channel (in_*): one transfer is a bus read, a bus write or the load
// of one ROM image byte, the kind on in_tuser. Every input transfer yields
// exactly one output transfer (out_*): the byte read and the region that
// answered; writes, loads and unmapped reads return 0 with region 3.
// Configuration (cfg_*): window registers written by index; write them only
// while idle, which the block itself does not enforce.
// Pipeline: the memory is read at the transfer edge into its registered read
// data, which is staged into the output register once that register is free.
// Throughput: one item per cycle while out_tready is high, set by the single
// port of each memory. Writes and bank selects take effect at the input
// transfer, so a following read sees them.
// Reset: registers take their reset values and bank 0 is selected, then the
// framebuffer is swept to zero, one entry a cycle, over all FB_BYTES entries;
// in_tready stays low during the sweep (configuration writes are accepted).
// Stall: with out_tready low the output register holds its result and one
// more item is taken into the read stage before in_tready drops.
module banked_memory_map_decoder #(
  parameter int RAM_DEPTH      = 32768,
  parameter int BANK_BYTES     = 16384,
  parameter int BANK_COUNT_MAX = 16,
  parameter int FB_BYTES       = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [bmmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmmd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: address[15:0], write_data[23:16], rom_index[41:24], rom_byte[49:42]
  input  logic [55:0]                     in_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]                      in_tuser,
  // output channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: read_data[7:0]
  output logic [7:0]                      out_tdata,
  // tuser: region_hit[1:0]
  output logic [1:0]                      out_tuser
);
  import bmmd_pkg::*;

  localparam int RAM_AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int FB_AW  = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
  localparam int BS_W   = (BANK_COUNT_MAX > 1) ? $clog2(BANK_COUNT_MAX) : 1;
  localparam logic [FB_AW-1:0] CLR_LAST = FB_AW'(FB_BYTES - 1);

  // configuration and bank registers
  logic [ADDR_W-1:0]     ram_start_r, ram_bytes_r, rom_start_r, fb_base_r;
  logic [ROM_SIZE_W-1:0] rom_size_r;
  logic [BS_W-1:0]       bank_sel_r;

  // control
  phase_t            phase_r, phase_nxt;
  logic [FB_AW-1:0]  clr_cnt_r;
  logic              clearing;
  logic              s1_valid_r, s1_valid_nxt;
  region_t           s1_region_r;
  logic              s1_adv;
  logic              accept;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r;
  region_t           out_region_r;
  logic [BYTE_W-1:0] s1_data;

  // input fields
  req_type_t         req;
  logic [ADDR_W-1:0] address;
  logic [BYTE_W-1:0] write_data;
  logic [ROM_AW-1:0] rom_index;
  logic [BYTE_W-1:0] rom_byte;

  // decode results
  decode_t           dec;
  logic [RAM_AW-1:0] ram_idx;
  logic [ROM_AW-1:0] rom_idx;
  logic [FB_AW-1:0]  fb_idx;
  region_t           rd_region;

  // memory ports
  logic              ram_we, ram_re, rom_we, rom_re, fb_we, fb_re;
  logic [ROM_AW-1:0] rom_addr;
  logic [FB_AW-1:0]  fb_addr;
  logic [BYTE_W-1:0] rom_wd, fb_wd;
  logic [BYTE_W-1:0] ram_rd_r, rom_rd_r, fb_rd_r;
  logic [BYTE_W-1:0] ram_mem [RAM_DEPTH];
  logic [BYTE_W-1:0] rom_mem [ROM_DEPTH];
  logic [BYTE_W-1:0] fb_mem  [FB_BYTES];

  // unpack the input transfer
  always_comb begin
    req        = req_type_t'(in_tuser);
    address    = in_tdata[15:0];
    write_data = in_tdata[23:16];
    rom_index  = in_tdata[41:24];
    rom_byte   = in_tdata[49:42];
  end

  bmmd_decode #(
    .RAM_DEPTH      (RAM_DEPTH),
    .BANK_BYTES     (BANK_BYTES),
    .BANK_COUNT_MAX (BANK_COUNT_MAX),
    .FB_BYTES       (FB_BYTES)
  ) u_decode (
    .address    (address),
    .write_data (write_data),
    .ram_start  (ram_start_r),
    .ram_bytes  (ram_bytes_r),
    .rom_start  (rom_start_r),
    .rom_size   (rom_size_r),
    .fb_base    (fb_base_r),
    .bank_sel   (bank_sel_r),
    .dec        (dec),
    .ram_idx    (ram_idx),
    .rom_idx    (rom_idx),
    .fb_idx     (fb_idx)
  );

  // phase next state
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_CLEAR: if (clr_cnt_r == CLR_LAST) phase_nxt = PH_RUN;
      PH_RUN:   phase_nxt = PH_RUN;
      default:  phase_nxt = PH_CLEAR;
    endcase
  end

  // phase outputs
  always_comb begin
    unique case (phase_r)
      PH_CLEAR: clearing = 1'b1;
      PH_RUN:   clearing = 1'b0;
      default:  clearing = 1'b1;
    endcase
  end

  // handshake and stage advance
  always_comb begin
    s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
    in_tready = !clearing && (!s1_valid_r || s1_adv);
    accept    = in_tvalid && in_tready;
    s1_valid_nxt  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // read priority and memory port control
  always_comb begin
    ram_we = 1'b0;
    ram_re = 1'b0;
    rom_we = 1'b0;
    rom_re = 1'b0;
    fb_we  = clearing;
    fb_re  = 1'b0;
    rd_region = REGION_NONE;
    if (accept) begin
      unique case (req)
        REQ_READ: begin
          priority if (dec.ram_hit) begin
            ram_re    = 1'b1;
            rd_region = REGION_RAM;
          end else if (dec.rom_hit) begin
            rom_re    = 1'b1;
            rd_region = REGION_ROM;
          end else if (dec.fb_hit) begin
            fb_re     = 1'b1;
            rd_region = REGION_FB;
          end else begin
            rd_region = REGION_NONE;
          end
        end
        REQ_WRITE: begin
          ram_we = dec.ram_hit;
          fb_we  = dec.fb_hit;
        end
        REQ_LOAD: rom_we = 1'b1;
        default: ;
      endcase
    end
    rom_addr = rom_we ? rom_index : rom_idx;
    rom_wd   = rom_byte;
    fb_addr  = clearing ? clr_cnt_r : fb_idx;
    fb_wd    = clearing ? '0 : write_data;
  end

  // ram store
  always_ff @(posedge clk) begin
    if (ram_we) ram_mem[ram_idx] <= write_data;
    if (ram_re) ram_rd_r <= ram_mem[ram_idx];
  end

  // rom image store
  always_ff @(posedge clk) begin
    if (rom_we) rom_mem[rom_addr] <= rom_wd;
    if (rom_re) rom_rd_r <= rom_mem[rom_addr];
  end

  // framebuffer store
  always_ff @(posedge clk) begin
    if (fb_we) fb_mem[fb_addr] <= fb_wd;
    if (fb_re) fb_rd_r <= fb_mem[fb_addr];
  end

  // pick the byte of the region that answered
  always_comb begin
    unique case (s1_region_r)
      REGION_RAM:  s1_data = ram_rd_r;
      REGION_ROM:  s1_data = rom_rd_r;
      REGION_FB:   s1_data = fb_rd_r;
      REGION_NONE: s1_data = UNMAPPED_BYTE;
      default:     s1_data = UNMAPPED_BYTE;
    endcase
  end

  // configuration and bank select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_start_r <= RAM_START_RST;
      ram_bytes_r <= RAM_BYTES_RST;
      rom_start_r <= ROM_START_RST;
      rom_size_r  <= ROM_SIZE_RST;
      fb_base_r   <= FB_BASE_RST;
      bank_sel_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RAM_START: ram_start_r <= cfg_wdata[ADDR_W-1:0];
          CFG_RAM_BYTES: ram_bytes_r <= cfg_wdata[ADDR_W-1:0];
          CFG_ROM_START: rom_start_r <= cfg_wdata[ADDR_W-1:0];
          CFG_ROM_SIZE:  rom_size_r  <= cfg_wdata[ROM_SIZE_W-1:0];
          CFG_FB_BASE:   fb_base_r   <= cfg_wdata[ADDR_W-1:0];
          default: ;
        endcase
      end
      if (accept && (req == REQ_WRITE) && dec.bank_wr) begin
        bank_sel_r <= write_data[BS_W-1:0];
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CLEAR;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      if (clearing) clr_cnt_r <= clr_cnt_r + 1'b1;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) s1_region_r <= rd_region;
    if (s1_adv) begin
      out_data_r   <= s1_data;
      out_region_r <= s1_region_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_region_r;

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CLEAR) |-> !in_tready)
    else $error("input taken during framebuffer clearing");

  a_bank_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(bank_sel_r) < 32'(BANK_COUNT_MAX))
    else $error("bank select beyond bank count");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while both stages are stalled");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted item lost before read stage");
`endif

endmodule

### verif/tb_banked_memory_map_decoder.sv
module tb_banked_memory_map_decoder;
  import bmmd_pkg::*;

  localparam int RAM_DEPTH      = 32768;
  localparam int BANK_BYTES     = 16384;
  localparam int BANK_COUNT_MAX = 16;
  localparam int FB_BYTES       = 1024;

  // request kind that the block has to ignore
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [17:0] rom_idx;
    logic [7:0]  rom_byte;
  } bus_req_t;

  typedef struct packed {
    logic [7:0] rdata;
    region_t    region;
  } bus_rsp_t;

  typedef struct packed {
    logic [15:0]           ram_start;
    logic [15:0]           ram_bytes;
    logic [15:0]           rom_start;
    logic [ROM_SIZE_W-1:0] rom_size;
    logic [15:0]           fb_base;
  } map_cfg_t;

  localparam map_cfg_t MAP_RESET =
    {RAM_START_RST, RAM_BYTES_RST, ROM_START_RST, ROM_SIZE_RST, FB_BASE_RST};
  // ram covers the framebuffer, full sixteen-bank image
  localparam map_cfg_t MAP_OVERLAP = {16'h0000, 16'h8000, 16'hC000, 19'h40000, 16'h2000};
  // windows running past the top of the bus, one-byte image
  localparam map_cfg_t MAP_TOP     = {16'hFFFF, 16'h8000, 16'hFF00, 19'h00001, 16'hFFFF};
  // empty ram, oversized image on top of the framebuffer
  localparam map_cfg_t MAP_LOW     = {16'h4000, 16'h0000, 16'h0000, 19'h7FFFF, 16'h0000};
  // ram size beyond the store, partial second bank, framebuffer under rom
  localparam map_cfg_t MAP_SPLIT   = {16'h8000, 16'hFFFF, 16'h4000, 19'h06001, 16'h3F00};

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [55:0]           in_tdata  = '0;
  logic [1:0]            in_tuser  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic [1:0]            out_tuser;

  // memory map copy used for prediction
  map_cfg_t   m_map;
  logic [3:0] m_bank;
  logic [7:0] ram_mem  [RAM_DEPTH];
  logic [7:0] rom_mem  [ROM_DEPTH];
  logic [7:0] fb_mem   [FB_BYTES];
  bit         ram_seen [RAM_DEPTH];
  bit         rom_seen [ROM_DEPTH];

  bus_rsp_t bus_rsp_due [$];
  bus_rsp_t chk_want;
  int       fails = 0;
  int       n_sent = 0;
  int       n_maps = 0;
  int       rd_hits [4];
  int       gap_pct = 0;
  int       stall_pct = 0;

  banked_memory_map_decoder #(
    .RAM_DEPTH     (RAM_DEPTH),
    .BANK_BYTES    (BANK_BYTES),
    .BANK_COUNT_MAX(BANK_COUNT_MAX),
    .FB_BYTES      (FB_BYTES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  // window helpers
  function automatic int unsigned ram_len();
    return (m_map.ram_bytes > RAM_DEPTH) ? RAM_DEPTH : m_map.ram_bytes;
  endfunction

  function automatic int unsigned rom_len();
    return (m_map.rom_size > ROM_DEPTH) ? ROM_DEPTH : m_map.rom_size;
  endfunction

  function automatic int unsigned bank_limit();
    int unsigned n;
    n = (rom_len() + BANK_BYTES - 1) / BANK_BYTES;
    return (n > BANK_COUNT_MAX) ? BANK_COUNT_MAX : n;
  endfunction

  function automatic bit ram_hit(input int unsigned a, output int unsigned idx);
    idx = (a - m_map.ram_start) % RAM_DEPTH;
    return a >= m_map.ram_start && a < m_map.ram_start + ram_len();
  endfunction

  function automatic bit fb_hit(input int unsigned a, output int unsigned idx);
    idx = (a - m_map.fb_base) % FB_BYTES;
    return a >= m_map.fb_base && a < m_map.fb_base + FB_BYTES;
  endfunction

  // read decode in priority order: ram, banked rom, framebuffer
  function automatic region_t decode_read(input int unsigned a, output int unsigned idx);
    int unsigned off;
    if (ram_hit(a, idx)) return REGION_RAM;
    if (m_map.rom_size != 0 && a >= m_map.rom_start && a < m_map.rom_start + BANK_BYTES) begin
      off = (a - m_map.rom_start) + m_bank * BANK_BYTES;
      if (off < rom_len()) begin
        idx = off % ROM_DEPTH;
        return REGION_ROM;
      end
    end
    if (fb_hit(a, idx)) return REGION_FB;
    return REGION_NONE;
  endfunction

  // one bus access against the map copy, returns the expected response
  function automatic bus_rsp_t decode_access(input bus_req_t req);
    bus_rsp_t    rsp;
    int unsigned idx;
    region_t     hit;
    rsp.rdata  = UNMAPPED_BYTE;
    rsp.region = REGION_NONE;
    case (req.kind)
      REQ_READ: begin
        hit = decode_read(req.addr, idx);
        rsp.region = hit;
        case (hit)
          REGION_RAM: rsp.rdata = ram_mem[idx];
          REGION_ROM: rsp.rdata = rom_mem[idx];
          REGION_FB:  rsp.rdata = fb_mem[idx];
          default: ;
        endcase
        rd_hits[hit]++;
      end
      REQ_WRITE: begin
        if (ram_hit(req.addr, idx)) begin
          ram_mem[idx]  = req.wdata;
          ram_seen[idx] = 1'b1;
        end
        if (fb_hit(req.addr, idx)) fb_mem[idx] = req.wdata;
        if (req.addr == BANK_PORT && req.wdata < bank_limit()) m_bank = req.wdata[3:0];
      end
      REQ_LOAD: begin
        rom_mem[req.rom_idx]  = req.rom_byte;
        rom_seen[req.rom_idx] = 1'b1;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic reset_model();
    int k;
    m_map  = MAP_RESET;
    m_bank = '0;
    for (k = 0; k < FB_BYTES; k++) fb_mem[k] = '0;
  endtask

  // send one request, record its expected response on transfer
  task automatic issue(input bus_req_t req);
    bus_req_t    r;
    bus_rsp_t    rsp;
    int unsigned idx;
    region_t     hit;
    r = req;
    // a read of a never-written entry becomes the write or load that fills it
    if (r.kind == REQ_READ) begin
      hit = decode_read(r.addr, idx);
      if (hit == REGION_RAM && !ram_seen[idx]) begin
        r.kind = REQ_WRITE;
      end else if (hit == REGION_ROM && !rom_seen[idx]) begin
        r.kind    = REQ_LOAD;
        r.rom_idx = 18'(idx);
      end
    end
    rsp = decode_access(r);
    // sender idle cycles
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, r.rom_byte, r.rom_idx, r.wdata, r.addr};
    in_tuser  <= r.kind;
    do @(posedge clk); while (in_tready !== 1'b1);
    bus_rsp_due.push_back(rsp);
    n_sent++;
  endtask

  // stop sending and let every expected response come back
  task automatic wait_idle();
    int n;
    in_tvalid <= 1'b0;
    n = 0;
    while (bus_rsp_due.size() != 0 && n < 50000) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // program all window registers while the block is idle
  task automatic apply_map(input map_cfg_t c);
    wait_idle();
    cfg_put(CFG_RAM_START, 19'(c.ram_start));
    cfg_put(CFG_RAM_BYTES, 19'(c.ram_bytes));
    cfg_put(CFG_ROM_START, 19'(c.rom_start));
    cfg_put(CFG_ROM_SIZE,  c.rom_size);
    cfg_put(CFG_FB_BASE,   19'(c.fb_base));
    cfg_we <= 1'b0;
    m_map = c;
    n_maps++;
  endtask

  task automatic rd(input logic [15:0] a);
    issue({REQ_READ, a, 8'h00, 18'h0, 8'h00});
  endtask

  task automatic wr(input logic [15:0] a, input logic [7:0] d);
    issue({REQ_WRITE, a, d, 18'h0, 8'h00});
  endtask

  task automatic ld(input logic [17:0] idx, input logic [7:0] b);
    issue({REQ_LOAD, 16'h0000, 8'h00, idx, b});
  endtask

  task automatic junk();
    issue({REQ_UNKNOWN, 16'hFFFF, 8'hFF, 18'h3FFFF, 8'hFF});
  endtask

  // address mostly near window edges so reads find written entries
  function automatic logic [15:0] pick_addr();
    int unsigned span;
    span = $urandom_range(0, 7);
    case ($urandom_range(0, 9))
      0, 1:    return 16'(m_map.ram_start + span);
      2:       return 16'(m_map.ram_start + ram_len() - 1 - span);
      3, 4:    return 16'(m_map.rom_start + span);
      5:       return 16'(m_map.rom_start + BANK_BYTES - 1 - span);
      6:       return 16'(m_map.fb_base + $urandom_range(0, FB_BYTES - 1));
      7:       return BANK_PORT;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [17:0] pick_rom_idx();
    int unsigned span;
    span = $urandom_range(0, 7);
    case ($urandom_range(0, 3))
      0:       return 18'(m_bank * BANK_BYTES + span);
      1:       return 18'(m_bank * BANK_BYTES + BANK_BYTES - 1 - span);
      2:       return 18'($urandom_range(0, BANK_COUNT_MAX - 1) * BANK_BYTES + span);
      default: return 18'($urandom_range(0, ROM_DEPTH - 1));
    endcase
  endfunction

  function automatic map_cfg_t rand_map();
    map_cfg_t c;
    c.ram_start = 16'($urandom_range(0, 16'hFFFF));
    c.ram_bytes = 16'($urandom_range(0, RAM_DEPTH));
    c.rom_start = 16'($urandom_range(0, 16'hFFFF));
    c.rom_size  = 19'($urandom_range(0, ROM_DEPTH));
    c.fb_base   = 16'($urandom_range(0, 16'hFFFF));
    return c;
  endfunction

  // random mix of reads, writes, bank selects, loads and unknown kinds
  task automatic run_traffic(input int n);
    bus_req_t    r;
    int unsigned roll;
    int          k;
    for (k = 0; k < n; k++) begin
      if (k == n / 2) wait_idle();
      roll       = $urandom_range(0, 99);
      r.addr     = pick_addr();
      r.wdata    = 8'($urandom_range(0, 255));
      r.rom_idx  = pick_rom_idx();
      r.rom_byte = 8'($urandom_range(0, 255));
      if (roll < 45) begin
        r.kind = REQ_READ;
      end else if (roll < 78) begin
        r.kind = REQ_WRITE;
        if (r.addr == BANK_PORT && roll[0]) r.wdata = 8'($urandom_range(0, BANK_COUNT_MAX + 2));
      end else if (roll < 94) begin
        r.kind = REQ_LOAD;
      end else begin
        r.kind = REQ_UNKNOWN;
        r.addr = 16'($urandom_range(0, 16'hFFFF));
      end
      issue(r);
    end
  endtask

  // reset map: framebuffer only, no ram, no rom
  task automatic test_reset_map();
    gap_pct   = 0;
    stall_pct = 0;
    rd(16'h2000);
    rd(16'h23FF);
    rd(16'h2400);
    rd(16'h0000);
    rd(16'hC000);
    wr(16'h2005, 8'hA5);
    rd(16'h2005);
    wr(BANK_PORT, 8'h00);
    ld(18'h3FFFF, 8'hFF);
    ld(18'h00000, 8'h00);
    junk();
    rd(16'hFFFF);
  endtask

  // ram over framebuffer, banked rom and bank port range
  task automatic test_ram_rom_fb_decode();
    apply_map(MAP_OVERLAP);
    wr(16'h0000, 8'hFF);
    wr(16'h7FFF, 8'h80);
    rd(16'h0000);
    rd(16'h7FFF);
    wr(16'h2001, 8'h5A);
    rd(16'h2001);
    rd(16'h8000);
    ld(18'h00000, 8'h11);
    ld(18'h3FFFF, 8'hEE);
    rd(16'hC000);
    wr(BANK_PORT, 8'h0F);
    rd(16'hFFFF);
    wr(BANK_PORT, 8'h10);
    wr(BANK_PORT, 8'hFF);
    rd(16'hFFFF);
  endtask

  // every idling combination on the same map
  task automatic test_backpressure();
    apply_map(MAP_OVERLAP);
    gap_pct = 0;  stall_pct = 0;  run_traffic(100);
    gap_pct = 73; stall_pct = 0;  run_traffic(100);
    gap_pct = 0;  stall_pct = 73; run_traffic(100);
    gap_pct = 38; stall_pct = 38; run_traffic(100);
  endtask

  // windows at the ends of the bus and an oversized image
  task automatic test_window_extremes();
    gap_pct   = 38;
    stall_pct = 38;
    apply_map(MAP_TOP);
    run_traffic(80);
    apply_map(MAP_LOW);
    run_traffic(80);
  endtask

  // bank selection survives a smaller image
  task automatic test_rom_shrink();
    map_cfg_t c;
    gap_pct   = 0;
    stall_pct = 73;
    apply_map(MAP_SPLIT);
    run_traffic(60);
    wr(BANK_PORT, 8'h01);
    c = MAP_SPLIT;
    c.rom_size = 19'h00100;
    apply_map(c);
    run_traffic(60);
  endtask

  task automatic test_random_maps();
    gap_pct   = 73;
    stall_pct = 0;
    apply_map(rand_map());
    run_traffic(60);
    gap_pct   = 38;
    stall_pct = 73;
    apply_map(rand_map());
    run_traffic(60);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (bus_rsp_due.size() == 0) begin
        $error("result with nothing expected: read_data %0h region_hit %0d",
               out_tdata, out_tuser);
        fails++;
      end else begin
        chk_want = bus_rsp_due.pop_front();
        if (out_tdata !== chk_want.rdata) begin
          $error("read_data: expected %0h, got %0h", chk_want.rdata, out_tdata);
          fails++;
        end
        if (out_tuser !== chk_want.region) begin
          $error("region_hit: expected %0d, got %0d", chk_want.region, out_tuser);
          fails++;
        end
      end
    end
  end

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_map();
    test_ram_rom_fb_decode();
    test_backpressure();
    test_window_extremes();
    test_rom_shrink();
    test_random_maps();
    wait_idle();
    if (bus_rsp_due.size() != 0) begin
      $error("%0d results never arrived", bus_rsp_due.size());
      fails++;
    end
    $display("covered %0d transfers over %0d address maps", n_sent, n_maps);
    $display("reads answered by ram %0d, rom %0d, framebuffer %0d, unmapped %0d",
             rd_hits[0], rd_hits[1], rd_hits[2], rd_hits[3]);
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
